@@ sv/tope_pkg.sv @@
// Shared types and constants for the twin-output plant with event trigger.
`default_nettype none

package tope_pkg;

    localparam int COEF_W     = 16;
    localparam int IO_W       = 32;
    localparam int GAP_W      = 16;
    localparam int TAPS       = 6;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_OUT1_OWN   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_OUT2_OWN   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_CROSS      = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINTS       = 8'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLDS      = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_INTERVALS   = 8'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_EVENT_MODE      = 8'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_OUTPUTS = 8'd7;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic signed [IO_W-1:0] drive_one;
        logic signed [IO_W-1:0] drive_two;
    } in_item_t;

    typedef struct packed {
        logic signed [IO_W-1:0]  out_one;
        logic signed [IO_W-1:0]  out_two;
        logic                    fire_one;
        logic                    fire_two;
        logic                    fire_any;
        logic        [GAP_W-1:0] gap_one;
        logic        [GAP_W-1:0] gap_two;
    } out_item_t;

endpackage

`default_nettype wire

@@ sv/tope_mac.sv @@
// Six-tap multiply-accumulate with floor shift and saturation for one plant output.
`default_nettype none

module tope_mac
    import tope_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 12,
    parameter int HIST_W         = 32
) (
    input  wire logic signed [COEF_W-1:0]     coef [TAPS],
    input  wire logic signed [HIST_W-1:0]     data [TAPS],
    output logic signed      [DATA_WIDTH-1:0] result
);

    localparam int PW = HIST_W + COEF_W;
    localparam int SW = PW + 3;

    localparam logic signed [SW-1:0] MAXV =
        $signed({{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] MINV =
        $signed({{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}});

    logic signed [PW-1:0] prod [TAPS];
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] shifted;

    always_comb begin
        acc = '0;
        for (int i = 0; i < TAPS; i++) begin
            prod[i] = PW'(coef[i]) * PW'(data[i]);
            acc     = acc + SW'(prod[i]);
        end
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > MAXV) begin
            result = MAXV[DATA_WIDTH-1:0];
        end else if (shifted < MINV) begin
            result = MINV[DATA_WIDTH-1:0];
        end else begin
            result = shifted[DATA_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/tope_trig.sv @@
// Send-on-delta trigger decision and interval counter update for one output.
`default_nettype none

module tope_trig
    import tope_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic signed [DATA_WIDTH-1:0]  y,
    input  wire logic signed [IO_W-1:0]        setpoint,
    input  wire logic signed [IO_W-1:0]        threshold,
    input  wire logic        [COUNT_WIDTH-1:0] count,
    input  wire logic        [GAP_W-1:0]       max_interval,
    input  wire logic                          event_mode,
    output logic                               fire,
    output logic             [COUNT_WIDTH-1:0] count_next
);

    localparam int DW = ((DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W) + 2;
    localparam int CW = (COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] dev_abs;
    logic                 near_miss;
    logic                 overdue;

    always_comb begin
        diff      = DW'(y) - DW'(setpoint);
        dev_abs   = (diff < 0) ? -diff : diff;
        near_miss = dev_abs >= DW'(threshold);
        overdue   = CW'(count) >= CW'(max_interval);
        fire      = !event_mode || near_miss || overdue;
        if (fire) begin
            count_next = COUNT_ONE;
        end else if (count == COUNT_TOP) begin
            count_next = count;
        end else begin
            count_next = count + COUNT_ONE;
        end
    end

endmodule

`default_nettype wire

@@ sv/twin_output_plant_with_event_trigger_core.sv @@
// Top level: request and result registers, configuration, plant state and datapath.
// A tick request is held in the request register, and its result in the result register.
// One request per cycle unless results stall; combinational twelve-product MAC path.
// A restart request updates the state in that same step and yields no result.
// Reset clears the handshake state and all configuration registers, zeroes the
// output and drive histories and sets both interval counters to one.
`default_nettype none

module twin_output_plant_with_event_trigger_core
    import tope_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 12,
    parameter int COUNT_WIDTH    = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HIST_W = (DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    logic [CFG_DATA_W-1:0] coef_out1_own_reg;
    logic [CFG_DATA_W-1:0] coef_out2_own_reg;
    logic [CFG_DATA_W-1:0] coef_cross_reg;
    logic [CFG_DATA_W-1:0] setpoints_reg;
    logic [CFG_DATA_W-1:0] thresholds_reg;
    logic [2*GAP_W-1:0]    max_intervals_reg;
    logic                  event_mode_reg;
    logic [CFG_DATA_W-1:0] initial_outputs_reg;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;
    logic        advance;

    logic signed [HIST_W-1:0]      hist_out_one_reg   [2];
    logic signed [HIST_W-1:0]      hist_out_two_reg   [2];
    logic signed [IO_W-1:0]        hist_drive_one_reg [2];
    logic signed [IO_W-1:0]        hist_drive_two_reg [2];
    logic        [COUNT_WIDTH-1:0] count_one_reg;
    logic        [COUNT_WIDTH-1:0] count_two_reg;

    logic signed [COEF_W-1:0]      coef_one [TAPS];
    logic signed [COEF_W-1:0]      coef_two [TAPS];
    logic signed [HIST_W-1:0]      data_one [TAPS];
    logic signed [HIST_W-1:0]      data_two [TAPS];
    logic signed [DATA_WIDTH-1:0]  y_one;
    logic signed [DATA_WIDTH-1:0]  y_two;
    logic                          fire_one;
    logic                          fire_two;
    logic        [COUNT_WIDTH-1:0] count_one_next;
    logic        [COUNT_WIDTH-1:0] count_two_next;
    logic signed [HIST_W-1:0]      init_one;
    logic signed [HIST_W-1:0]      init_two;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && ((in_item_reg.cmd == CMD_RESTART)
                                        || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_out1_own_reg   <= '0;
            coef_out2_own_reg   <= '0;
            coef_cross_reg      <= '0;
            setpoints_reg       <= '0;
            thresholds_reg      <= '0;
            max_intervals_reg   <= '0;
            event_mode_reg      <= 1'b0;
            initial_outputs_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_COEF_OUT1_OWN:   coef_out1_own_reg   <= cfg_data;
                CFG_COEF_OUT2_OWN:   coef_out2_own_reg   <= cfg_data;
                CFG_COEF_CROSS:      coef_cross_reg      <= cfg_data;
                CFG_SETPOINTS:       setpoints_reg       <= cfg_data;
                CFG_THRESHOLDS:      thresholds_reg      <= cfg_data;
                CFG_MAX_INTERVALS:   max_intervals_reg   <= cfg_data[2*GAP_W-1:0];
                CFG_EVENT_MODE:      event_mode_reg      <= cfg_data[0];
                CFG_INITIAL_OUTPUTS: initial_outputs_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                coef_one[k]     = $signed(coef_out1_own_reg[k*COEF_W +: COEF_W]);
                coef_one[k + 4] = $signed(coef_cross_reg[k*COEF_W +: COEF_W]);
                coef_two[k]     = $signed(coef_out2_own_reg[k*COEF_W +: COEF_W]);
                coef_two[k + 4] = $signed(coef_out2_own_reg[(k+2)*COEF_W +: COEF_W]);
            end else begin
                coef_one[k] = $signed(coef_out1_own_reg[k*COEF_W +: COEF_W]);
                coef_two[k] = $signed(coef_cross_reg[k*COEF_W +: COEF_W]);
            end
        end
        data_one[0] = hist_out_one_reg[0];
        data_one[1] = hist_out_one_reg[1];
        data_one[2] = HIST_W'(hist_drive_one_reg[0]);
        data_one[3] = HIST_W'(hist_drive_one_reg[1]);
        data_one[4] = HIST_W'(hist_drive_two_reg[0]);
        data_one[5] = HIST_W'(hist_drive_two_reg[1]);
        data_two[0] = hist_out_two_reg[0];
        data_two[1] = hist_out_two_reg[1];
        data_two[2] = HIST_W'(hist_drive_one_reg[0]);
        data_two[3] = HIST_W'(hist_drive_one_reg[1]);
        data_two[4] = HIST_W'(hist_drive_two_reg[0]);
        data_two[5] = HIST_W'(hist_drive_two_reg[1]);
        init_one    = HIST_W'($signed(initial_outputs_reg[IO_W-1:0]));
        init_two    = HIST_W'($signed(initial_outputs_reg[2*IO_W-1:IO_W]));
    end

    tope_mac #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HIST_W         (HIST_W)
    ) u_mac_one (
        .coef   (coef_one),
        .data   (data_one),
        .result (y_one)
    );

    tope_mac #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HIST_W         (HIST_W)
    ) u_mac_two (
        .coef   (coef_two),
        .data   (data_two),
        .result (y_two)
    );

    tope_trig #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trig_one (
        .y            (y_one),
        .setpoint     ($signed(setpoints_reg[IO_W-1:0])),
        .threshold    ($signed(thresholds_reg[IO_W-1:0])),
        .count        (count_one_reg),
        .max_interval (max_intervals_reg[GAP_W-1:0]),
        .event_mode   (event_mode_reg),
        .fire         (fire_one),
        .count_next   (count_one_next)
    );

    tope_trig #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trig_two (
        .y            (y_two),
        .setpoint     ($signed(setpoints_reg[2*IO_W-1:IO_W])),
        .threshold    ($signed(thresholds_reg[2*IO_W-1:IO_W])),
        .count        (count_two_reg),
        .max_interval (max_intervals_reg[2*GAP_W-1:GAP_W]),
        .event_mode   (event_mode_reg),
        .fire         (fire_two),
        .count_next   (count_two_next)
    );

    always_comb begin
        out_item_next.out_one  = IO_W'(y_one);
        out_item_next.out_two  = IO_W'(y_two);
        out_item_next.fire_one = fire_one;
        out_item_next.fire_two = fire_two;
        out_item_next.fire_any = fire_one || fire_two;
        out_item_next.gap_one  = GAP_W'(count_one_reg);
        out_item_next.gap_two  = GAP_W'(count_two_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && (in_item_reg.cmd == CMD_TICK)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (in_item_reg.cmd == CMD_TICK)) begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                hist_out_one_reg[k]   <= '0;
                hist_out_two_reg[k]   <= '0;
                hist_drive_one_reg[k] <= '0;
                hist_drive_two_reg[k] <= '0;
            end
            count_one_reg <= COUNT_ONE;
            count_two_reg <= COUNT_ONE;
        end else if (advance) begin
            if (in_item_reg.cmd == CMD_RESTART) begin
                for (int k = 0; k < 2; k++) begin
                    hist_out_one_reg[k]   <= init_one;
                    hist_out_two_reg[k]   <= init_two;
                    hist_drive_one_reg[k] <= '0;
                    hist_drive_two_reg[k] <= '0;
                end
                count_one_reg <= COUNT_ONE;
                count_two_reg <= COUNT_ONE;
            end else begin
                hist_out_one_reg[1]   <= hist_out_one_reg[0];
                hist_out_one_reg[0]   <= HIST_W'(y_one);
                hist_out_two_reg[1]   <= hist_out_two_reg[0];
                hist_out_two_reg[0]   <= HIST_W'(y_two);
                hist_drive_one_reg[1] <= hist_drive_one_reg[0];
                hist_drive_one_reg[0] <= in_item_reg.drive_one;
                hist_drive_two_reg[1] <= hist_drive_two_reg[0];
                hist_drive_two_reg[0] <= in_item_reg.drive_two;
                count_one_reg         <= count_one_next;
                count_two_reg         <= count_two_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/tope_checker.sv @@
// Port-level checker for the plant core, bound to the top level.
`default_nettype none

module tope_checker
    import tope_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("Waiting request changed or was withdrawn.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed or was dropped.");

    a_fire_any: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fire_any == (m_data.fire_one || m_data.fire_two)))
        else $error("Combined trigger disagrees with the per-output triggers.");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("Request refused while the result side can move.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("Result appeared without a request accepted before it.");

endmodule

bind twin_output_plant_with_event_trigger_core tope_checker u_tope_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the twin-output plant core: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module tb;
    import tope_pkg::*;

    localparam int     FRAC        = 12;
    localparam int     RUN_PHASES  = 10;
    localparam int     PHASE_ITEMS = 130;
    localparam longint OUT_MAX     = 2147483647;
    localparam longint OUT_MIN     = -OUT_MAX - 1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [63:0] own1_coefs;
    logic [63:0] own2_coefs;
    logic [63:0] cross_coefs;
    logic [63:0] setpoint_pair;
    logic [63:0] threshold_pair;
    logic [31:0] max_gap_pair;
    logic        event_on;
    logic [63:0] init_pair;

    longint      y1_hist [2];
    longint      y2_hist [2];
    longint      u1_hist [2];
    longint      u2_hist [2];
    logic [15:0] gap1;
    logic [15:0] gap2;

    in_item_t    request_q [$];
    out_item_t   plant_results_q [$];
    bit          req_pending = 1'b0;
    bit          drain_hold  = 1'b0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          mismatches  = 0;

    twin_output_plant_with_event_trigger_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint tap(input logic [63:0] words, input int k);
        return longint'($signed(words[16*k +: 16]));
    endfunction

    function automatic longint clamp_q16(input longint acc);
        longint y;
        y = acc >>> FRAC;
        if (y > OUT_MAX) begin
            y = OUT_MAX;
        end else if (y < OUT_MIN) begin
            y = OUT_MIN;
        end
        return y;
    endfunction

    function automatic bit crosses(input longint y, input logic [31:0] sp, input logic [31:0] beta,
                                   input logic [15:0] cnt, input logic [15:0] hmax);
        longint dev;
        dev = y - longint'($signed(sp));
        if (dev < 0) begin
            dev = -dev;
        end
        return (dev >= longint'($signed(beta))) || (cnt >= hmax);
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] cnt, input bit fired);
        if (fired) begin
            return 16'd1;
        end
        return (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
    endfunction

    function automatic bit plant_step(input in_item_t req, output out_item_t res);
        longint y1;
        longint y2;
        bit     f1;
        bit     f2;
        res = '0;
        if (req.cmd == CMD_RESTART) begin
            y1_hist[0] = longint'($signed(init_pair[31:0]));
            y1_hist[1] = y1_hist[0];
            y2_hist[0] = longint'($signed(init_pair[63:32]));
            y2_hist[1] = y2_hist[0];
            u1_hist = '{0, 0};
            u2_hist = '{0, 0};
            gap1 = 16'd1;
            gap2 = 16'd1;
            return 1'b0;
        end
        y1 = clamp_q16(tap(own1_coefs, 0) * y1_hist[0] + tap(own1_coefs, 1) * y1_hist[1]
                     + tap(own1_coefs, 2) * u1_hist[0] + tap(own1_coefs, 3) * u1_hist[1]
                     + tap(cross_coefs, 0) * u2_hist[0] + tap(cross_coefs, 1) * u2_hist[1]);
        y2 = clamp_q16(tap(own2_coefs, 0) * y2_hist[0] + tap(own2_coefs, 1) * y2_hist[1]
                     + tap(cross_coefs, 2) * u1_hist[0] + tap(cross_coefs, 3) * u1_hist[1]
                     + tap(own2_coefs, 2) * u2_hist[0] + tap(own2_coefs, 3) * u2_hist[1]);
        y1_hist[1] = y1_hist[0];
        y1_hist[0] = y1;
        y2_hist[1] = y2_hist[0];
        y2_hist[0] = y2;
        u1_hist[1] = u1_hist[0];
        u1_hist[0] = longint'(req.drive_one);
        u2_hist[1] = u2_hist[0];
        u2_hist[0] = longint'(req.drive_two);
        f1 = 1'b1;
        f2 = 1'b1;
        if (event_on) begin
            f1 = crosses(y1, setpoint_pair[31:0], threshold_pair[31:0], gap1, max_gap_pair[15:0]);
            f2 = crosses(y2, setpoint_pair[63:32], threshold_pair[63:32], gap2,
                         max_gap_pair[31:16]);
        end
        res.out_one  = y1[31:0];
        res.out_two  = y2[31:0];
        res.fire_one = f1;
        res.fire_two = f2;
        res.fire_any = f1 | f2;
        res.gap_one  = gap1;
        res.gap_two  = gap2;
        gap1 = bump(gap1, f1);
        gap2 = bump(gap2, f2);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    function automatic logic [31:0] pick_drive();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(32'h40000)) - 32'h20000;
        endcase
    endfunction

    function automatic logic [63:0] coef_words(input int lo_span, input int hi_span);
        logic [63:0] words;
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                words[16*k +: 16] = 16'($urandom_range(2 * lo_span)) - 16'(lo_span);
            end else begin
                words[16*k +: 16] = 16'($urandom_range(2 * hi_span)) - 16'(hi_span);
            end
        end
        return words;
    endfunction

    function automatic logic [63:0] extreme_or(input logic [63:0] v);
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            default: return v;
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(7))
            0: return $urandom() | 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom_range(32'h20000);
        endcase
    endfunction

    function automatic logic [15:0] pick_max_gap();
        case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return 16'($urandom());
            default: return 16'($urandom_range(10));
        endcase
    endfunction

    task automatic queue_request(input logic c, input logic [31:0] d1, input logic [31:0] d2);
        in_item_t r;
        r.cmd       = c;
        r.drive_one = d1;
        r.drive_two = d2;
        request_q.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_addr  <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_COEF_OUT1_OWN:   own1_coefs     = value;
            CFG_COEF_OUT2_OWN:   own2_coefs     = value;
            CFG_COEF_CROSS:      cross_coefs    = value;
            CFG_SETPOINTS:       setpoint_pair  = value;
            CFG_THRESHOLDS:      threshold_pair = value;
            CFG_MAX_INTERVALS:   max_gap_pair   = value[31:0];
            CFG_EVENT_MODE:      event_on       = value[0];
            CFG_INITIAL_OUTPUTS: init_pair      = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || req_pending || plant_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (!req_pending) begin
                if (drain_hold && plant_results_q.size() == 0) begin
                    drain_hold = 1'b0;
                end else if (plant_results_q.size() != 0 && $urandom_range(299) == 0) begin
                    drain_hold = 1'b1;
                end
                if (!drain_hold && request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_data      <= request_q.pop_front();
                    s_valid     <= 1'b1;
                    req_pending = 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t fresh;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (plant_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result with no request waiting: %h", m_data);
                    end
                end else begin
                    want = plant_results_q.pop_front();
                    check_field("out_one", 64'(want.out_one), 64'(m_data.out_one));
                    check_field("out_two", 64'(want.out_two), 64'(m_data.out_two));
                    check_field("fire_one", 64'(want.fire_one), 64'(m_data.fire_one));
                    check_field("fire_two", 64'(want.fire_two), 64'(m_data.fire_two));
                    check_field("fire_any", 64'(want.fire_any), 64'(m_data.fire_any));
                    check_field("gap_one", 64'(want.gap_one), 64'(m_data.gap_one));
                    check_field("gap_two", 64'(want.gap_two), 64'(m_data.gap_two));
                end
            end
            if (s_valid && s_ready) begin
                req_pending = 1'b0;
                if (plant_step(s_data, fresh)) begin
                    plant_results_q.push_back(fresh);
                end
            end
        end
    end

    initial begin
        int kind;
        own1_coefs     = '0;
        own2_coefs     = '0;
        cross_coefs    = '0;
        setpoint_pair  = '0;
        threshold_pair = '0;
        max_gap_pair   = '0;
        event_on       = 1'b0;
        init_pair      = '0;
        y1_hist        = '{0, 0};
        y2_hist        = '{0, 0};
        u1_hist        = '{0, 0};
        u2_hist        = '{0, 0};
        gap1           = 16'd1;
        gap2           = 16'd1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        queue_request(CMD_TICK, 32'h0001_0000, 32'hFFFF_0000);
        queue_request(CMD_TICK, 32'h0000_0000, 32'h0000_0000);
        wait_idle();

        write_reg(CFG_COEF_OUT1_OWN, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(CFG_COEF_OUT2_OWN, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        write_reg(CFG_COEF_CROSS, {16'h1000, 16'hF000, 16'h0800, 16'hF800});
        write_reg(CFG_SETPOINTS, {32'hFFFF_0000, 32'h0001_0000});
        write_reg(CFG_THRESHOLDS, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(CFG_MAX_INTERVALS, 64'hDEAD_BEEF_0003_0005);
        write_reg(CFG_EVENT_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_INITIAL_OUTPUTS, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(CFG_ADDR_W'(8), 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg('1, 64'h0123_4567_89AB_CDEF);

        queue_request(CMD_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(CMD_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(CMD_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_TICK, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_request(CMD_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_RESTART, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_TICK, 32'h8000_0000, 32'h8000_0000);
        queue_request(CMD_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_idle();

        write_reg(CFG_COEF_OUT1_OWN, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
        write_reg(CFG_COEF_OUT2_OWN, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
        write_reg(CFG_THRESHOLDS, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(CFG_MAX_INTERVALS, 64'({16'd0, 16'd4}));
        write_reg(CFG_EVENT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_EVENT_MODE, 64'd1);
        write_reg(CFG_INITIAL_OUTPUTS, 64'd0);
        queue_request(CMD_RESTART, 32'h0, 32'h0);
        for (int n = 0; n < 8; n++) begin
            queue_request(CMD_TICK, 32'h0001_0000, 32'hFFFF_0000);
        end
        wait_idle();

        for (int p = 0; p < RUN_PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if ($urandom_range(2) == 0) begin
                write_reg(CFG_COEF_OUT1_OWN, extreme_or({$urandom(), $urandom()}));
                write_reg(CFG_COEF_OUT2_OWN, extreme_or({$urandom(), $urandom()}));
            end else begin
                write_reg(CFG_COEF_OUT1_OWN, coef_words(16'h0400, 16'h1000));
                write_reg(CFG_COEF_OUT2_OWN, coef_words(16'h0400, 16'h1000));
            end
            write_reg(CFG_COEF_CROSS, extreme_or(coef_words(16'h1000, 16'h1000)));
            write_reg(CFG_SETPOINTS, extreme_or({32'($urandom_range(32'h80000)) - 32'h40000,
                                                 32'($urandom_range(32'h80000)) - 32'h40000}));
            write_reg(CFG_THRESHOLDS, {pick_threshold(), pick_threshold()});
            write_reg(CFG_MAX_INTERVALS, {$urandom(), pick_max_gap(), pick_max_gap()});
            write_reg(CFG_EVENT_MODE, {$urandom(), $urandom_range(32'hFFFF_FFFF) & ~32'h1}
                                      | 64'($urandom_range(3) != 0));
            write_reg(CFG_INITIAL_OUTPUTS, extreme_or({pick_drive(), pick_drive()}));
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_ADDR_W'($urandom_range(255, 8)), {$urandom(), $urandom()});
            end

            queue_request(CMD_RESTART, $urandom(), $urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(99);
                if (kind < 4) begin
                    queue_request(CMD_RESTART, $urandom(), $urandom());
                end else if (kind < 10) begin
                    queue_request(CMD_TICK, $urandom(), $urandom());
                end else begin
                    queue_request(CMD_TICK, pick_drive(), pick_drive());
                end
            end
            if (p == 1) begin
                while (plant_results_q.size() == 0) begin
                    @(posedge aclk);
                end
                drain_hold = 1'b1;
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ twin_output_plant_with_event_trigger_core.f @@
sv/tope_pkg.sv
sv/tope_mac.sv
sv/tope_trig.sv
sv/twin_output_plant_with_event_trigger_core.sv
sv/tope_checker.sv
dv/tb.sv
